>>> src/fsc_pkg.sv
// shared types and constants for the frustum sphere cull unit
package fsc_pkg;

    localparam int PLANE_COUNT = 6;
    // planes beyond the sixth do not exist
    localparam int CELL_COUNT  = (PLANE_COUNT < 6) ? PLANE_COUNT : 6;
    localparam int ROW_COUNT   = 4;
    localparam int REG_COUNT   = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int R2_W        = 62;

    typedef logic signed [31:0] word_t;
    typedef word_t [ROW_COUNT-1:0] vec4_t;

    typedef struct packed {
        word_t             cx;
        word_t             cy;
        word_t             cz;
        logic [R2_W-1:0]   r2;
        logic              in_frustum;
    } beat_t;

endpackage

>>> src/fsc_front.sv
// input register and radius squaring ahead of the plane cells
module fsc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fsc_pkg::word_t       center_x,
    input  fsc_pkg::word_t       center_y,
    input  fsc_pkg::word_t       center_z,
    input  logic [30:0]          radius,
    output logic                 beat_valid,
    input  logic                 beat_ready,
    output fsc_pkg::beat_t       beat
);
    import fsc_pkg::*;

    logic        s0_valid_reg;
    word_t       s0_cx_reg;
    word_t       s0_cy_reg;
    word_t       s0_cz_reg;
    logic [30:0] s0_rad_reg;
    logic        s1_valid_reg;
    beat_t       s1_beat_reg;
    beat_t       s1_beat_next;
    logic        s0_ready;
    logic        s1_ready;

    assign s1_ready = !s1_valid_reg || beat_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_stall = !s0_ready;

    always_comb
    begin
        s1_beat_next.cx         = s0_cx_reg;
        s1_beat_next.cy         = s0_cy_reg;
        s1_beat_next.cz         = s0_cz_reg;
        s1_beat_next.r2         = R2_W'(s0_rad_reg) * R2_W'(s0_rad_reg);
        s1_beat_next.in_frustum = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_cx_reg  <= center_x;
            s0_cy_reg  <= center_y;
            s0_cz_reg  <= center_z;
            s0_rad_reg <= radius;
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_beat_reg <= s1_beat_next;
        end
    end

    assign beat_valid = s1_valid_reg;
    assign beat       = s1_beat_reg;

endmodule

>>> src/fsc_cell.sv
// one plane cell: holds its plane and tests each passing beat against it
module fsc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsc_pkg::vec4_t       base,
    input  fsc_pkg::vec4_t       side,
    input  logic                 minus,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fsc_pkg::beat_t       in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fsc_pkg::beat_t       out_beat
);
    import fsc_pkg::*;

    // plane state, registered from the matrix, then squared and summed into the norm
    logic signed [32:0] coef_reg  [ROW_COUNT];
    logic signed [32:0] coef_next [ROW_COUNT];
    logic signed [65:0] sq_full   [3];
    logic [64:0]        sq_reg    [3];
    logic [64:0]        sq_next   [3];
    logic [65:0]        n2_reg;
    logic [65:0]        n2_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    beat_t b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg;
    beat_t b6_next;

    logic signed [64:0]  px_next, py_next, pz_next;
    logic signed [48:0]  pw_next;
    logic signed [64:0]  px1_reg, py1_reg, pz1_reg;
    logic signed [48:0]  pw1_reg;

    logic signed [66:0]  d_next;
    logic signed [66:0]  d2_reg;

    logic                neg_next;
    logic [65:0]         mag_next;
    logic [63:0]         qhh_next, qhl_next, qlh_next, qll_next;
    logic                neg3_reg;
    logic [65:0]         mag3_reg;
    logic [63:0]         qhh3_reg, qhl3_reg, qlh3_reg, qll3_reg;

    logic [65:0]         ll_next, lh_next, hh_next;
    logic [131:0]        rn_next;
    logic                neg4_reg;
    logic [65:0]         ll4_reg, lh4_reg, hh4_reg;
    logic [131:0]        rn4_reg;

    logic [131:0]        dd_next;
    logic                neg5_reg;
    logic [131:0]        dd5_reg;
    logic [131:0]        rn5_reg;

    always_comb
    begin
        for (int e = 0; e < ROW_COUNT; e++)
        begin
            if (minus)
            begin
                coef_next[e] = $signed({base[e][31], base[e]}) - $signed({side[e][31], side[e]});
            end
            else
            begin
                coef_next[e] = $signed({base[e][31], base[e]}) + $signed({side[e][31], side[e]});
            end
        end
        for (int e = 0; e < 3; e++)
        begin
            sq_full[e] = coef_reg[e] * coef_reg[e];
            sq_next[e] = sq_full[e][64:0];
        end
        n2_next = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ROW_COUNT; e++)
            begin
                coef_reg[e] <= '0;
            end
            for (int e = 0; e < 3; e++)
            begin
                sq_reg[e] <= '0;
            end
            n2_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
            sq_reg   <= sq_next;
            n2_reg   <= n2_next;
        end
    end

    // stage ready chain, a stage fills when empty or when it drains
    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        // plane distance terms
        px_next = coef_reg[0] * in_beat.cx;
        py_next = coef_reg[1] * in_beat.cy;
        pz_next = coef_reg[2] * in_beat.cz;
        pw_next = {coef_reg[3], 16'd0};

        d_next = 67'(px1_reg) + 67'(py1_reg) + 67'(pz1_reg) + 67'(pw1_reg);

        neg_next = d2_reg[66];
        mag_next = d2_reg[66] ? 66'(-d2_reg) : 66'(d2_reg);
        // r*r times plane norm, split into four partial products
        qhh_next = 64'(n2_reg[65:33]) * 64'(b2_reg.r2[61:31]);
        qhl_next = 64'(n2_reg[65:33]) * 64'(b2_reg.r2[30:0]);
        qlh_next = 64'(n2_reg[32:0])  * 64'(b2_reg.r2[61:31]);
        qll_next = 64'(n2_reg[32:0])  * 64'(b2_reg.r2[30:0]);

        ll_next = 66'(mag3_reg[32:0])  * 66'(mag3_reg[32:0]);
        lh_next = 66'(mag3_reg[32:0])  * 66'(mag3_reg[65:33]);
        hh_next = 66'(mag3_reg[65:33]) * 66'(mag3_reg[65:33]);
        rn_next = {4'd0, qhh3_reg, 64'd0} + {35'd0, qhl3_reg, 33'd0}
                + {37'd0, qlh3_reg, 31'd0} + {68'd0, qll3_reg};

        // cross term counts twice, hence the extra shift
        dd_next = {hh4_reg, 66'd0} + {32'd0, lh4_reg, 34'd0} + {66'd0, ll4_reg};

        b6_next            = b5_reg;
        b6_next.in_frustum = b5_reg.in_frustum & ~(neg5_reg && (dd5_reg > rn5_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            b1_reg  <= in_beat;
            px1_reg <= px_next;
            py1_reg <= py_next;
            pz1_reg <= pz_next;
            pw1_reg <= pw_next;
        end
        if (rdy2 && v1_reg)
        begin
            b2_reg <= b1_reg;
            d2_reg <= d_next;
        end
        if (rdy3 && v2_reg)
        begin
            b3_reg   <= b2_reg;
            neg3_reg <= neg_next;
            mag3_reg <= mag_next;
            qhh3_reg <= qhh_next;
            qhl3_reg <= qhl_next;
            qlh3_reg <= qlh_next;
            qll3_reg <= qll_next;
        end
        if (rdy4 && v3_reg)
        begin
            b4_reg   <= b3_reg;
            neg4_reg <= neg3_reg;
            ll4_reg  <= ll_next;
            lh4_reg  <= lh_next;
            hh4_reg  <= hh_next;
            rn4_reg  <= rn_next;
        end
        if (rdy5 && v4_reg)
        begin
            b5_reg   <= b4_reg;
            neg5_reg <= neg4_reg;
            dd5_reg  <= dd_next;
            rn5_reg  <= rn4_reg;
        end
        if (rdy6 && v5_reg)
        begin
            b6_reg <= b6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_beat  = b6_reg;

endmodule

>>> src/frustum_sphere_cull_unit.sv
// frustum sphere cull unit: matrix registers, front stage and a chain of plane cells
// path: front stage, then the six-stage multiply and compare pipeline in each plane cell
// throughput: one sphere per cycle while out_stall is low; each stage has its own valid
// bit so bubbles collapse
// reset: matrix registers clear to zero (every sphere reads as inside), pipeline empties;
// cell plane coefficients follow a written matrix via coef_reg, then sq_reg and n2_reg
module frustum_sphere_cull_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  fsc_pkg::word_t                     center_x,
    input  fsc_pkg::word_t                     center_y,
    input  fsc_pkg::word_t                     center_z,
    input  logic [30:0]                        radius,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               inside_res
);
    import fsc_pkg::*;

    word_t mat_reg [ROW_COUNT][ROW_COUNT];
    vec4_t col_vec [ROW_COUNT];

    beat_t               link_beat  [CELL_COUNT+1];
    logic [CELL_COUNT:0] link_valid;
    logic [CELL_COUNT:0] link_ready;

    // register 2*row+half holds columns 2*half and 2*half+1 of that row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                for (int c = 0; c < ROW_COUNT; c++)
                begin
                    mat_reg[r][c] <= '0;
                end
            end
        end
        else if (cfg_write && (cfg_index < CFG_INDEX_W'(REG_COUNT)))
        begin
            mat_reg[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[31:0];
            mat_reg[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[63:32];
        end
    end

    always_comb
    begin
        for (int c = 0; c < ROW_COUNT; c++)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                col_vec[c][r] = mat_reg[r][c];
            end
        end
    end

    fsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .radius     (radius),
        .beat_valid (link_valid[0]),
        .beat_ready (link_ready[0]),
        .beat       (link_beat[0])
    );

    // planes in order left, right, bottom, top, near, far
    for (genvar p = 0; p < CELL_COUNT; p++)
    begin : g_cell
        fsc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .base      (col_vec[ROW_COUNT-1]),
            .side      (col_vec[p >> 1]),
            .minus     (1'(p % 2)),
            .in_valid  (link_valid[p]),
            .in_ready  (link_ready[p]),
            .in_beat   (link_beat[p]),
            .out_valid (link_valid[p+1]),
            .out_ready (link_ready[p+1]),
            .out_beat  (link_beat[p+1])
        );
    end

    assign link_ready[CELL_COUNT] = !out_stall;
    assign out_valid              = link_valid[CELL_COUNT];
    assign inside_res             = link_beat[CELL_COUNT].in_frustum;

endmodule

>>> sim/frustum_sphere_cull_unit_tb.sv
// testbench for frustum_sphere_cull_unit: directed table then random spheres against a predictor
`timescale 1ns / 100ps

module frustum_sphere_cull_unit_tb;

    import fsc_pkg::*;

    localparam int LATENCY = 2 + 6 * CELL_COUNT;

    localparam logic [CFG_INDEX_W-1:0] REG_R0_C01 = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_R0_C23 = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_R1_C01 = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_R1_C23 = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_R2_C01 = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_R2_C23 = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_R3_C01 = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_R3_C23 = 4'd7;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_INDEX = 4'd15;

    localparam word_t Q_ONE = 32'sh0001_0000;
    localparam word_t Q_TWO = 32'sh0002_0000;
    localparam word_t W_MAX = 32'sh7FFF_FFFF;
    localparam word_t W_MIN = 32'sh8000_0000;
    localparam logic [30:0] R_MAX = 31'h7FFF_FFFF;

    localparam int PHASE_COUNT = 13;
    localparam int PHASE_ITEMS = 150;

    // wide enough for every exact product and sum of the plane test
    typedef logic signed [191:0] wide_t;
    localparam wide_t ONE_Q = 192'sd65536;

    typedef enum int {MAT_PERSP, MAT_SMALL, MAT_FULL, MAT_TOP, MAT_BOTTOM} mat_kind_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        word_t                cx;
        word_t                cy;
        word_t                cz;
        logic [30:0]          rad;
        bit                   typed;
        bit                   want;
    } step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    word_t                  center_x;
    word_t                  center_y;
    word_t                  center_z;
    logic [30:0]            radius;
    logic                   out_valid;
    logic                   out_stall;
    logic                   inside_res;

    word_t  coef [4][4];
    word_t  plan_mat [4][4];
    bit     expected_inside [$];
    step_t  dir_steps [$];
    int     mismatches = 0;
    int     burst_left = 0;
    int     stall_left = 0;
    int     stall_mode = 0;

    frustum_sphere_cull_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .radius     (radius),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // a sphere survives when no plane has it fully on the negative side
    function automatic bit sphere_inside(word_t cx, word_t cy, word_t cz, logic [30:0] rad);
        wide_t pl [4];
        wide_t ctr [3];
        wide_t d;
        wide_t nrm;
        wide_t rr;
        int    k;
        bit    in_frustum;
        in_frustum = 1'b1;
        ctr[0] = wide_t'(cx);
        ctr[1] = wide_t'(cy);
        ctr[2] = wide_t'(cz);
        rr = wide_t'(rad) * wide_t'(rad);
        for (int p = 0; p < CELL_COUNT; p++)
        begin
            k = p >> 1;
            for (int e = 0; e < 4; e++)
            begin
                if (p & 1)
                    pl[e] = wide_t'(coef[e][3]) - wide_t'(coef[e][k]);
                else
                    pl[e] = wide_t'(coef[e][3]) + wide_t'(coef[e][k]);
            end
            d = pl[0] * ctr[0] + pl[1] * ctr[1] + pl[2] * ctr[2] + pl[3] * ONE_Q;
            nrm = pl[0] * pl[0] + pl[1] * pl[1] + pl[2] * pl[2];
            if (d < 0 && d * d > nrm * rr)
                in_frustum = 1'b0;
        end
        return in_frustum;
    endfunction

    function automatic step_t cfg_step(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        step_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = data;
        return s;
    endfunction

    function automatic step_t sphere_step(word_t cx, word_t cy, word_t cz, logic [30:0] rad,
                                          bit typed, bit want);
        step_t s;
        s = '{default: '0};
        s.cx = cx;
        s.cy = cy;
        s.cz = cz;
        s.rad = rad;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    // random Q16.16 value between lo and hi whole units
    function automatic word_t rand_q(int lo, int hi);
        return word_t'(lo * 65536) + word_t'($urandom_range(0, (hi - lo) * 65536));
    endfunction

    function automatic word_t pick_extreme_word();
        case ($urandom_range(0, 4))
            0: return W_MAX;
            1: return W_MIN;
            2: return '0;
            3: return word_t'(-1);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx <= REG_R3_C23)
        begin
            coef[idx[2:1]][{idx[0], 1'b0}] = data[31:0];
            coef[idx[2:1]][{idx[0], 1'b1}] = data[63:32];
        end
        @(posedge clk);
    endtask

    // drop the write strobe and let the plane coefficients catch up
    task automatic close_cfg();
        @(negedge clk);
        cfg_write <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic drain_pipe();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_inside.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_sphere(input word_t cx, input word_t cy, input word_t cz,
                               input logic [30:0] rad, input bit typed, input bit want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 5))
                0, 1: gap = 0;
                2: gap = $urandom_range(10, 40);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        center_x <= cx;
        center_y <= cy;
        center_z <= cz;
        radius   <= rad;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_inside.push_back(typed ? want : sphere_inside(cx, cy, cz, rad));
    endtask

    task automatic load_plan();
        for (int r = 0; r < 4; r++)
            for (int h = 0; h < 2; h++)
                set_reg(CFG_INDEX_W'(REG_R0_C01 + 2 * r + h),
                        {plan_mat[r][2 * h + 1], plan_mat[r][2 * h]});
    endtask

    task automatic build_plan(input mat_kind_t kind);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                case (kind)
                    MAT_TOP:    plan_mat[r][c] = W_MAX;
                    MAT_BOTTOM: plan_mat[r][c] = W_MIN;
                    MAT_SMALL:  plan_mat[r][c] = rand_q(-2, 2);
                    MAT_FULL:   plan_mat[r][c] = ($urandom_range(0, 3) == 0) ?
                                                 pick_extreme_word() : word_t'($urandom);
                    default:    plan_mat[r][c] = ($urandom_range(0, 3) == 0) ?
                                                 word_t'($urandom_range(0, 512)) - 256 : '0;
                endcase
            end
        if (kind == MAT_PERSP)
        begin
            // left-handed perspective, small jitter on the off-diagonal terms
            plan_mat[0][0] = word_t'(32768 + $urandom_range(0, 98304));
            plan_mat[1][1] = word_t'(32768 + $urandom_range(0, 98304));
            plan_mat[2][2] = word_t'(65536 + $urandom_range(0, 8192));
            plan_mat[2][3] = Q_ONE;
            plan_mat[3][2] = -word_t'($urandom_range(4096, 65536));
            plan_mat[3][3] = '0;
        end
    endtask

    task automatic send_random_sphere(input mat_kind_t kind);
        word_t       cx;
        word_t       cy;
        word_t       cz;
        logic [30:0] rad;
        case ($urandom_range(0, 9))
            7, 8:
            begin
                cx = word_t'($urandom);
                cy = word_t'($urandom);
                cz = word_t'($urandom);
                rad = 31'($urandom);
            end
            9:
            begin
                cx = pick_extreme_word();
                cy = pick_extreme_word();
                cz = pick_extreme_word();
                rad = ($urandom_range(0, 1) == 0) ? R_MAX : 31'($urandom_range(0, 1));
            end
            default:
            begin
                cx = rand_q(-8, 8);
                cy = rand_q(-8, 8);
                cz = (kind == MAT_PERSP) ? rand_q(-2, 24) : rand_q(-8, 8);
                rad = ($urandom_range(0, 4) == 0) ? '0 : 31'($urandom_range(0, 4 * 65536));
            end
        endcase
        send_sphere(cx, cy, cz, rad, 1'b0, 1'b0);
    endtask

    // receiver backpressure, switching between a few patterns
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ((stall_left % 11) < 4);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_inside.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, actual %0b",
                         $time, inside_res);
                mismatches++;
            end
            else
            begin
                if (inside_res !== expected_inside[0])
                begin
                    $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                             $time, expected_inside[0], inside_res);
                    mismatches++;
                end
                void'(expected_inside.pop_front());
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[frustum_sphere_cull_unit] ERROR");
        $finish;
    end

    initial
    begin
        bit        cfg_open;
        mat_kind_t kind;
        step_t     s;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        center_x  = '0;
        center_y  = '0;
        center_z  = '0;
        radius    = '0;
        out_stall = 1'b0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                coef[r][c] = '0;

        // matrix out of reset: every plane is zero, so everything is inside
        dir_steps.push_back(sphere_step('0, '0, '0, '0, 1'b1, 1'b1));
        dir_steps.push_back(sphere_step(W_MAX, W_MAX, W_MAX, R_MAX, 1'b1, 1'b1));
        dir_steps.push_back(sphere_step(W_MIN, W_MIN, W_MIN, '0, 1'b1, 1'b1));
        // writes past the last register are dropped
        for (int i = REG_R3_C23 + 1; i <= REG_TOP_INDEX; i++)
            dir_steps.push_back(cfg_step(CFG_INDEX_W'(i), {$urandom, $urandom}));
        dir_steps.push_back(sphere_step(3 * Q_ONE, -5 * Q_ONE, 7 * Q_ONE, 31'h1_0000, 1'b1, 1'b1));
        // degenerate planes with negative w cull regardless of radius
        dir_steps.push_back(cfg_step(REG_R3_C23, {-Q_ONE, 32'h0}));
        dir_steps.push_back(sphere_step('0, '0, '0, R_MAX, 1'b1, 1'b0));
        dir_steps.push_back(sphere_step(W_MAX, W_MIN, W_MAX, '0, 1'b1, 1'b0));
        dir_steps.push_back(cfg_step(REG_R3_C23, {Q_ONE, 32'h0}));
        dir_steps.push_back(sphere_step(W_MIN, W_MIN, W_MIN, R_MAX, 1'b1, 1'b1));
        // identity matrix: unit cube frustum
        dir_steps.push_back(cfg_step(REG_R0_C01, {32'h0, Q_ONE}));
        dir_steps.push_back(cfg_step(REG_R0_C23, 64'h0));
        dir_steps.push_back(cfg_step(REG_R1_C01, {Q_ONE, 32'h0}));
        dir_steps.push_back(cfg_step(REG_R1_C23, 64'h0));
        dir_steps.push_back(cfg_step(REG_R2_C01, 64'h0));
        dir_steps.push_back(cfg_step(REG_R2_C23, {32'h0, Q_ONE}));
        dir_steps.push_back(cfg_step(REG_R3_C01, 64'h0));
        dir_steps.push_back(cfg_step(REG_R3_C23, {Q_ONE, 32'h0}));
        dir_steps.push_back(sphere_step('0, '0, '0, '0, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step(Q_TWO, '0, '0, '0, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step(-Q_TWO, '0, '0, '0, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step('0, Q_TWO, '0, '0, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step('0, -Q_TWO, '0, '0, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step('0, '0, Q_TWO, '0, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step('0, '0, -Q_TWO, '0, 1'b0, 1'b0));
        // touching the plane exactly, then one lsb short of it
        dir_steps.push_back(sphere_step(Q_TWO, '0, '0, 31'h1_0000, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step(Q_TWO, '0, '0, 31'h0_FFFF, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step('0, '0, -3 * Q_ONE, 31'h2_0000, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step(W_MAX, W_MAX, W_MAX, R_MAX, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step(W_MIN, W_MIN, W_MIN, R_MAX, 1'b0, 1'b0));
        dir_steps.push_back(sphere_step(W_MIN, W_MAX, W_MIN, '0, 1'b0, 1'b0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_open = 1'b0;
        foreach (dir_steps[i])
        begin
            s = dir_steps[i];
            if (s.is_cfg)
            begin
                if (!cfg_open)
                begin
                    drain_pipe();
                    cfg_open = 1'b1;
                end
                set_reg(s.idx, s.data);
            end
            else
            begin
                if (cfg_open)
                begin
                    close_cfg();
                    cfg_open = 1'b0;
                end
                send_sphere(s.cx, s.cy, s.cz, s.rad, s.typed, s.want);
            end
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph == 0)
                kind = MAT_TOP;
            else if (ph == 1)
                kind = MAT_BOTTOM;
            else
            begin
                case ($urandom_range(0, 9))
                    5, 6, 7: kind = MAT_SMALL;
                    8, 9:    kind = MAT_FULL;
                    default: kind = MAT_PERSP;
                endcase
            end
            drain_pipe();
            if ($urandom_range(0, 2) == 0)
                set_reg(4'($urandom_range(REG_R3_C23 + 1, REG_TOP_INDEX)), {$urandom, $urandom});
            build_plan(kind);
            load_plan();
            close_cfg();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_sphere(kind);
        end

        drain_pipe();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_inside.size() == 0)
            $display("[frustum_sphere_cull_unit] OK");
        else
            $display("[frustum_sphere_cull_unit] ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/fsc_pkg.sv
src/fsc_front.sv
src/fsc_cell.sv
src/frustum_sphere_cull_unit.sv
sim/frustum_sphere_cull_unit_tb.sv
